[rtl/prfc_pkg.sv]
`timescale 1ns / 1ps

package prfc_pkg;

   // Default build parameters
   localparam int MAX_LENGTH_DEF  = 64;
   localparam int COUNT_WIDTH_DEF = 16;

   // Register reset values and fixed limits
   localparam logic [6:0]  LENGTH_RESET  = 7'd4;
   localparam logic [15:0] TIMEOUT_RESET = 16'd50000;
   localparam int          MIN_LENGTH    = 4;

   // Register indexes on the csr_ port
   localparam logic REG_LENGTH  = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   // CRC-16 generator polynomial and byte mask
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam logic [15:0] LOW_BYTE = 16'h00FF;

   // Result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR  = 2'd2;
   localparam logic [1:0] STATUS_CRC_ERR  = 2'd3;

   // One result from the decoder core to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] byte_value;
      logic [5:0] byte_index;
      logic       last;
      logic [1:0] status;
   } result_type;

   // CRC-16 update over one byte, data bits taken LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                            input logic [7:0]  data);
      logic [15:0] crc;
      logic        fb;
      crc = crc_in;
      for (int i = 0; i < 8; i++) begin
         fb  = data[i] ^ crc[15];
         crc = {crc[14:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

endpackage

[rtl/prfc_core.sv]
`timescale 1ns / 1ps

module prfc_core #(
   parameter int MAX_LENGTH  = prfc_pkg::MAX_LENGTH_DEF,
   parameter int COUNT_WIDTH = prfc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 start_req,
   input  logic                 line_level,
   input  logic [6:0]           expected_length,
   input  logic [15:0]          timeout_limit,
   output prfc_pkg::result_type result
);

   localparam int LW  = $clog2(MAX_LENGTH + 1);
   localparam int BW  = (LW > 6) ? LW : 6;
   localparam int CLW = (LW > 7) ? LW : 7;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_WAIT_START = 4'b0010,
      PH_MEASURE    = 4'b0100,
      PH_WAIT_HIGH  = 4'b1000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [15:0]            wait_ff, wait_in;
   logic [COUNT_WIDTH-1:0] low_ff, low_in;
   logic [COUNT_WIDTH-1:0] high_ff, high_in;
   logic [2:0]             bitpos_ff, bitpos_in;
   logic [7:0]             shift_ff, shift_in;
   logic [BW-1:0]          bytes_ff, bytes_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             count_ff, count_in;
   logic [7:0]             crc_low_ff, crc_low_in;

   logic [CLW-1:0]         len_wide;
   logic [LW-1:0]          len;
   logic [16:0]            wait_next;
   logic [COUNT_WIDTH-1:0] low_inc, high_inc;
   logic [COUNT_WIDTH+1:0] low_thr, high_thr;
   logic                   bit_take;
   logic [7:0]             value;
   logic [BW:0]            idx_p1, idx_p2, len_ext;

   // Length in use, clamped to the supported range
   always_comb begin
      len_wide = CLW'(expected_length);
      if (len_wide < CLW'(prfc_pkg::MIN_LENGTH)) begin
         len_wide = CLW'(prfc_pkg::MIN_LENGTH);
      end
      if (len_wide > CLW'(MAX_LENGTH)) begin
         len_wide = CLW'(MAX_LENGTH);
      end
      len = LW'(len_wide);
   end

   // Saturating counters and 1.5x thresholds
   assign low_inc   = (low_ff == '1) ? low_ff : low_ff + 1'b1;
   assign high_inc  = (high_ff == '1) ? high_ff : high_ff + 1'b1;
   assign low_thr   = ({2'b00, low_ff} + {1'b0, low_ff, 1'b0}) >> 1;
   assign high_thr  = ({2'b00, high_ff} + {1'b0, high_ff, 1'b0}) >> 1;
   assign wait_next = {1'b0, wait_ff} + 17'd1;

   // Byte position arithmetic; a decided bit always equals the current line level
   assign idx_p1  = {1'b0, bytes_ff} + (BW+1)'(1);
   assign idx_p2  = {1'b0, bytes_ff} + (BW+1)'(2);
   assign len_ext = (BW+1)'(len);
   assign value   = shift_ff | ({7'd0, line_level} << bitpos_ff);

   // Next state and result for one accepted sample
   always_comb begin
      phase_in   = phase_ff;
      wait_in    = wait_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      bitpos_in  = bitpos_ff;
      shift_in   = shift_ff;
      bytes_in   = bytes_ff;
      crc_in     = crc_ff;
      count_in   = count_ff;
      crc_low_in = crc_low_ff;
      bit_take   = 1'b0;
      result     = '0;

      if (accept) begin
         if (start_req) begin
            phase_in   = PH_WAIT_START;
            wait_in    = '0;
            low_in     = '0;
            high_in    = '0;
            bitpos_in  = '0;
            shift_in   = '0;
            bytes_in   = '0;
            crc_in     = '0;
            count_in   = '0;
            crc_low_in = '0;
         end else begin
            case (phase_ff)
               PH_WAIT_START: begin
                  if (wait_next > {1'b0, timeout_limit}) begin
                     result.valid      = 1'b1;
                     result.byte_value = '0;
                     result.byte_index = bytes_ff[5:0];
                     result.last       = 1'b1;
                     result.status     = prfc_pkg::STATUS_TIMEOUT;
                     phase_in          = PH_IDLE;
                  end else begin
                     wait_in = wait_next[15:0];
                     if (!line_level) begin
                        low_in   = '0;
                        high_in  = '0;
                        phase_in = PH_MEASURE;
                     end
                  end
               end
               PH_MEASURE: begin
                  if (!line_level) begin
                     low_in = low_inc;
                     if (high_ff != '0 && {2'b00, low_inc} > high_thr) begin
                        phase_in = PH_WAIT_HIGH;
                        bit_take = 1'b1;
                     end
                  end else begin
                     high_in = high_inc;
                     if (low_ff != '0 && {2'b00, high_inc} > low_thr) begin
                        phase_in = PH_WAIT_START;
                        wait_in  = '0;
                        bit_take = 1'b1;
                     end
                  end
               end
               PH_WAIT_HIGH: begin
                  if (line_level) begin
                     phase_in = PH_WAIT_START;
                     wait_in  = '0;
                  end
               end
               default: begin
               end
            endcase

            // Bit assembly, byte completion and frame checks
            if (bit_take) begin
               if (bitpos_ff != 3'd7) begin
                  shift_in  = value;
                  bitpos_in = bitpos_ff + 3'd1;
               end else begin
                  bitpos_in = '0;
                  shift_in  = '0;
                  bytes_in  = bytes_ff + 1'b1;
                  if (bytes_ff == '0) begin
                     count_in = value;
                  end
                  if (idx_p2 < len_ext) begin
                     crc_in = prfc_pkg::crc_byte(crc_ff, value);
                  end else if (idx_p2 == len_ext) begin
                     crc_low_in = value;
                  end
                  result.valid      = 1'b1;
                  result.byte_value = value;
                  result.byte_index = bytes_ff[5:0];
                  result.last       = 1'b0;
                  result.status     = prfc_pkg::STATUS_OK;
                  if (idx_p1 >= len_ext) begin
                     result.last = 1'b1;
                     phase_in    = PH_IDLE;
                     if (count_ff != 8'(len)) begin
                        result.status = prfc_pkg::STATUS_LEN_ERR;
                     end else if ((crc_ff & prfc_pkg::LOW_BYTE) != {8'd0, crc_low_ff} ||
                                  crc_ff[15:8] != value) begin
                        result.status = prfc_pkg::STATUS_CRC_ERR;
                     end
                  end
               end
            end
         end
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         wait_ff    <= '0;
         low_ff     <= '0;
         high_ff    <= '0;
         bitpos_ff  <= '0;
         shift_ff   <= '0;
         bytes_ff   <= '0;
         crc_ff     <= '0;
         count_ff   <= '0;
         crc_low_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         bitpos_ff  <= bitpos_in;
         shift_ff   <= shift_in;
         bytes_ff   <= bytes_in;
         crc_ff     <= crc_in;
         count_ff   <= count_in;
         crc_low_ff <= crc_low_in;
      end
   end

endmodule

[rtl/pulse_ratio_rx_frame_checker.sv]
`timescale 1ns / 1ps

// Single-wire pulse-ratio response receiver with count-byte and CRC-16 check.
// req_ channel: one line sample per transfer; req_tdata[0] is the line level,
// req_tuser set starts a new response (that sample is not decoded).
// rsp_ channel: one transfer per received byte, or one on a timeout; tlast
// marks the final byte or the timeout, tuser carries the status code.
// csr_ port: index 0 sets the expected length, index 1 the timeout limit;
// write only while no response is in progress.
// Throughput: one sample per cycle while rsp_ is not stalled; the decode between the state
// registers and the output register is combinational. Latency: a result appears on
// rsp_ in the cycle after the sample that completes it.
// The output register holds a result until rsp_tready; req_tready follows it,
// so a stalled receiver stalls the sample stream, one sample per freed slot.
// Reset (synchronous) makes the decoder idle, loads length 4 and timeout
// 50000; samples are ignored until a start request.
module pulse_ratio_rx_frame_checker #(
   parameter int MAX_LENGTH  = prfc_pkg::MAX_LENGTH_DEF,
   parameter int COUNT_WIDTH = prfc_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // sample input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] line_level, [7:1] zero
   input  logic        req_tuser,   // [0] start_req
   // byte results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] byte_value, [13:8] byte_index, [15:14] zero
   output logic        rsp_tlast,   // last
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [6:0]           length_ff;
   logic [15:0]          timeout_ff;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic                 rsp_last_ff;
   logic [1:0]           rsp_user_ff;
   logic                 accept;
   prfc_pkg::result_type result;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= prfc_pkg::LENGTH_RESET;
         timeout_ff <= prfc_pkg::TIMEOUT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            prfc_pkg::REG_LENGTH:  length_ff  <= csr_wdata[6:0];
            prfc_pkg::REG_TIMEOUT: timeout_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Take a sample whenever the output slot is free or being emptied
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   prfc_core #(
      .MAX_LENGTH  (MAX_LENGTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .start_req       (req_tuser),
      .line_level      (req_tdata[0]),
      .expected_length (length_ff),
      .timeout_limit   (timeout_ff),
      .result          (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && result.valid) begin
         rsp_data_ff <= {2'b00, result.byte_index, result.byte_value};
         rsp_last_ff <= result.last;
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'b0001,
      PH_WAIT_START = 4'b0010,
      PH_MEASURE    = 4'b0100,
      PH_WAIT_HIGH  = 4'b1000
   } rx_phase_type;

   typedef enum {
      FRAME_GOOD,
      FRAME_BAD_COUNT,
      FRAME_BAD_CRC,
      FRAME_ABORT,
      FRAME_TRAILING
   } frame_kind_type;

   typedef struct packed {
      logic [7:0] byte_val;
      logic [5:0] byte_idx;
      logic       is_last;
      logic [1:0] status;
   } rx_byte_type;

   // Decoder predictor plus the queue of bytes it expects on rsp_
   class rx_scoreboard;
      rx_phase_type phase;
      logic [15:0]  wait_cnt;
      logic [15:0]  low_cnt;
      logic [15:0]  high_cnt;
      logic [2:0]   bit_pos;
      logic [7:0]   shift_reg;
      logic [6:0]   byte_cnt;
      logic [15:0]  crc_acc;
      logic [7:0]   count_val;
      logic [7:0]   crc_low_rx;
      logic [6:0]   length_reg;
      logic [15:0]  timeout_reg;
      rx_byte_type  expected_q[$];
      int           errors;

      function new();
         length_reg  = prfc_pkg::LENGTH_RESET;
         timeout_reg = prfc_pkg::TIMEOUT_RESET;
         errors      = 0;
         clear();
      endfunction

      function void clear();
         phase      = PH_IDLE;
         wait_cnt   = '0;
         low_cnt    = '0;
         high_cnt   = '0;
         bit_pos    = '0;
         shift_reg  = '0;
         byte_cnt   = '0;
         crc_acc    = '0;
         count_val  = '0;
         crc_low_rx = '0;
      endfunction

      // CRC-16 over one byte, data LSB first
      static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
         logic [15:0] c;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            if (data[i] != c[15]) c = (c << 1) ^ prfc_pkg::CRC_POLY;
            else c = c << 1;
         end
         return c;
      endfunction

      // Expected length after clamping to the legal range
      function int length_in_use();
         int n;
         n = length_reg;
         if (n < prfc_pkg::MIN_LENGTH) n = prfc_pkg::MIN_LENGTH;
         if (n > prfc_pkg::MAX_LENGTH_DEF) n = prfc_pkg::MAX_LENGTH_DEF;
         return n;
      endfunction

      function void write_reg(logic idx, logic [15:0] val);
         if (idx == prfc_pkg::REG_LENGTH) length_reg = val[6:0];
         else timeout_reg = val;
      endfunction

      function void push_result(logic [7:0] v, logic [6:0] idx, logic last,
                                logic [1:0] st);
         rx_byte_type r;
         r.byte_val = v;
         r.byte_idx = idx[5:0];
         r.is_last  = last;
         r.status   = st;
         expected_q.push_back(r);
      endfunction

      // Shift in one decided bit; a full byte becomes an expected transfer
      function void take_bit(logic b);
         int         len;
         int         idx;
         logic [7:0] v;
         logic [1:0] st;
         len = length_in_use();
         v = shift_reg | (8'(b) << bit_pos);
         if (bit_pos < 3'd7) begin
            shift_reg = v;
            bit_pos++;
            return;
         end
         bit_pos   = '0;
         shift_reg = '0;
         idx       = byte_cnt;
         if (idx == 0) count_val = v;
         if (idx + 2 < len) crc_acc = crc16_step(crc_acc, v);
         else if (idx + 2 == len) crc_low_rx = v;
         byte_cnt++;
         st = prfc_pkg::STATUS_OK;
         if (idx + 1 >= len) begin
            if (count_val != len) st = prfc_pkg::STATUS_LEN_ERR;
            else if (crc_acc[7:0] != crc_low_rx || crc_acc[15:8] != v) begin
               st = prfc_pkg::STATUS_CRC_ERR;
            end
            phase = PH_IDLE;
         end
         push_result(v, 7'(idx), idx + 1 >= len, st);
      endfunction

      // Called for every accepted sample transfer
      function void note_sample(logic start, logic line);
         int next_wait;
         if (start) begin
            clear();
            phase = PH_WAIT_START;
            return;
         end
         case (phase)
            PH_WAIT_START: begin
               next_wait = int'(wait_cnt) + 1;
               if (next_wait > int'(timeout_reg)) begin
                  push_result(8'd0, byte_cnt, 1'b1, prfc_pkg::STATUS_TIMEOUT);
                  phase = PH_IDLE;
               end else begin
                  wait_cnt = 16'(next_wait);
                  if (!line) begin
                     low_cnt  = '0;
                     high_cnt = '0;
                     phase    = PH_MEASURE;
                  end
               end
            end
            PH_MEASURE: begin
               // counters saturate; decision on a 3:2 ratio
               if (!line) begin
                  if (low_cnt != '1) low_cnt++;
                  if (high_cnt != 0 && int'(low_cnt) > ((3 * int'(high_cnt)) >> 1)) begin
                     phase = PH_WAIT_HIGH;
                     take_bit(1'b0);
                  end
               end else begin
                  if (high_cnt != '1) high_cnt++;
                  if (low_cnt != 0 && int'(high_cnt) > ((3 * int'(low_cnt)) >> 1)) begin
                     phase    = PH_WAIT_START;
                     wait_cnt = '0;
                     take_bit(1'b1);
                  end
               end
            end
            PH_WAIT_HIGH: begin
               if (line) begin
                  phase    = PH_WAIT_START;
                  wait_cnt = '0;
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
         if (act !== exp) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
            errors++;
         end
      endfunction

      // Called for every accepted result transfer
      function void check_byte(logic [15:0] data, logic last, logic [1:0] user);
         rx_byte_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: result with nothing expected: expected none, actual %h/%b/%h",
                     $time, data, last, user);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         compare_field("byte_value", 16'(e.byte_val), 16'(data[7:0]));
         compare_field("byte_index", 16'(e.byte_idx), 16'(data[13:8]));
         compare_field("tdata padding", 16'd0, 16'(data[15:14]));
         compare_field("last", 16'(e.is_last), 16'(last));
         compare_field("status", 16'(e.status), 16'(user));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] line_level, [7:1] zero
   logic        req_tuser;    // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] byte_value, [13:8] byte_index, [15:14] zero
   logic        rsp_tlast;    // last
   logic [1:0]  rsp_tuser;    // [1:0] status
   logic        csr_we;
   logic        csr_addr;
   logic [15:0] csr_wdata;

   rx_scoreboard sb;
   bit           tx_no_gaps;
   bit           rx_no_stall;
   int           hold_cycles;
   int           samples_sent;
   int           len_used;

   // {start_req, line_level}: idle samples, starts while idle, measuring and waiting for high, ratio ties
   localparam logic [1:0] DIRECTED_SEQ [22] = '{
      2'b00, 2'b01, 2'b10, 2'b01, 2'b00, 2'b11, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01,
      2'b01, 2'b01, 2'b00, 2'b00, 2'b00, 2'b01, 2'b01, 2'b00, 2'b00, 2'b00, 2'b11
   };

   pulse_ratio_rx_frame_checker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // One sample transfer after a random gap, or with no gap while tx_no_gaps is set
   task automatic send_sample(input logic start, input logic line);
      int gap;
      gap = tx_no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {7'd0, line};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(start, line);
      samples_sent++;
   endtask

   // Line waveform for one bit, starting from a wait for the falling edge
   task automatic send_bit(input logic b);
      int lows;
      int highs;
      if (b) begin
         lows  = $urandom_range(2, 4);
         highs = ((3 * (lows - 1)) >> 1) + 1;
         repeat (lows) send_sample(1'b0, 1'b0);
         repeat (highs) send_sample(1'b0, 1'b1);
      end else begin
         lows  = $urandom_range(3, 6);
         highs = (lows >= 4) ? $urandom_range(1, 2) : 1;
         repeat (lows) send_sample(1'b0, 1'b0);
         repeat (highs) send_sample(1'b0, 1'b1);
         repeat ($urandom_range(1, 3)) send_sample(1'b0, 1'b0);
         send_sample(1'b0, 1'b1);
      end
      // occasional idle high time before the next bit
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_sample(1'b0, 1'b1);
   endtask

   task automatic send_byte(input logic [7:0] b);
      int i;
      for (i = 0; i < 8; i++) send_bit(b[i]);
   endtask

   // Start request followed by a response: count byte, payload, CRC low then high
   task automatic send_frame(input frame_kind_type kind);
      logic [7:0]  frame[$];
      logic [15:0] crc;
      int          n;
      int          nsend;
      int          pos;
      int          i;
      n   = len_used;
      crc = '0;
      frame.push_back(8'(n));
      if (kind == FRAME_BAD_COUNT) frame[0] = frame[0] ^ (8'd1 << $urandom_range(0, 7));
      for (i = 1; i < n - 2; i++) frame.push_back(8'($urandom));
      for (i = 0; i < n - 2; i++) crc = rx_scoreboard::crc16_step(crc, frame[i]);
      frame.push_back(crc[7:0]);
      frame.push_back(crc[15:8]);
      if (kind == FRAME_BAD_CRC) begin
         pos = $urandom_range(1, n - 1);
         frame[pos] = frame[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      nsend = n;
      if (kind == FRAME_ABORT) nsend = $urandom_range(0, (n > 6) ? 5 : n - 1);
      send_sample(1'b1, 1'($urandom));
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) send_sample(1'b0, 1'b1);
      for (i = 0; i < nsend; i++) send_byte(frame[i]);
      // bytes after the end are ignored by an idle decoder
      if (kind == FRAME_TRAILING) repeat ($urandom_range(1, 2)) send_byte(8'($urandom));
   endtask

   // Random line activity with rare start requests
   task automatic send_noise();
      send_sample(1'b1, 1'($urandom));
      repeat ($urandom_range(20, 80)) send_sample($urandom_range(0, 31) == 0, 1'($urandom));
   endtask

   // Mixed traffic; the last frame always runs to completion so the block ends idle
   task automatic run_frames(input int count);
      int i;
      int r;
      for (i = 0; i < count; i++) begin
         r = $urandom_range(0, 15);
         if (r <= 8) send_frame(FRAME_GOOD);
         else if (r == 9) send_frame(FRAME_BAD_COUNT);
         else if (r == 10) send_frame(FRAME_BAD_CRC);
         else if (r == 11) send_frame(FRAME_ABORT);
         else if (r == 12) send_noise();
         else if (r == 13) begin
            tx_no_gaps  = 1'b1;
            rx_no_stall = 1'b1;
            send_frame(FRAME_GOOD);
            tx_no_gaps  = 1'b0;
            rx_no_stall = 1'b0;
         end else send_frame(FRAME_TRAILING);
      end
      send_frame(FRAME_GOOD);
   endtask

   // Wait until every expected byte has been taken, plus the block latency
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int length, input int tmo);
      csr_we    <= 1'b1;
      csr_addr  <= prfc_pkg::REG_LENGTH;
      csr_wdata <= 16'(length);
      @(posedge clock);
      sb.write_reg(prfc_pkg::REG_LENGTH, 16'(length));
      csr_addr  <= prfc_pkg::REG_TIMEOUT;
      csr_wdata <= 16'(tmo);
      @(posedge clock);
      sb.write_reg(prfc_pkg::REG_TIMEOUT, 16'(tmo));
      csr_we   <= 1'b0;
      len_used = sb.length_in_use();
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rx_no_stall ? 0 : $urandom_range(0, 7);
         if (hold_cycles > 0) begin
            stall       = hold_cycles;
            hold_cycles = 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
      end
   end

   // Main sequence
   initial begin
      int i;
      int length;
      int tmo;
      sb           = new();
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = prfc_pkg::REG_LENGTH;
      csr_wdata    = '0;
      tx_no_gaps   = 1'b0;
      rx_no_stall  = 1'b0;
      hold_cycles  = 0;
      samples_sent = 0;
      len_used     = sb.length_in_use();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed samples with the reset register values
      for (i = 0; i < 22; i++) send_sample(DIRECTED_SEQ[i][1], DIRECTED_SEQ[i][0]);
      run_frames(1);
      drain();

      // timeout on a short limit, then samples while idle
      set_config(4, 2);
      send_sample(1'b1, 1'b1);
      repeat (3) send_sample(1'b0, 1'b1);
      send_sample(1'b0, 1'b0);
      drain();

      // length below the minimum, tightest timeout
      set_config(0, 1);
      run_frames(3);
      drain();

      // receiver holding off mid-frame so the block fills and stalls its input
      set_config(8, 65535);
      hold_cycles = 600;
      send_frame(FRAME_GOOD);
      drain();

      // length above the maximum; partial frame ended by a timeout
      set_config(127, 16);
      send_frame(FRAME_ABORT);
      repeat (20) send_sample(1'b0, 1'b1);
      drain();

      set_config(3, prfc_pkg::TIMEOUT_RESET);
      run_frames(0);
      drain();

      // random settings, mostly short frames
      while (samples_sent < 1800) begin
         length = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
         case ($urandom_range(0, 3))
            0: tmo = 1;
            1: tmo = $urandom_range(2, 40);
            default: tmo = $urandom_range(41, 65535);
         endcase
         set_config(length, tmo);
         run_frames($urandom_range(0, 2));
         drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
